// File: rtl/core/pac_pkg.sv
package pac_pkg;

  localparam int unsigned COORD_BITS   = 16;
  localparam int unsigned MAX_VERTICES = 1024;

  localparam int unsigned SUM_BITS   = COORD_BITS + 1;
  localparam int unsigned CROSS_BITS = 2 * COORD_BITS + 1;
  localparam int unsigned PROD_BITS  = SUM_BITS + CROSS_BITS;
  localparam int unsigned AREA_BITS  = 43;
  localparam int unsigned MOM_BITS   = 60;
  localparam int unsigned CEN_BITS   = 24;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned DEN_BITS   = AREA_BITS + 1;
  localparam int unsigned QUO_BITS   = CEN_BITS + 1;
  localparam int unsigned DIV_STEPS  = MOM_BITS + FRAC_BITS;
  localparam int unsigned DIV_IT_BITS = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_AREA = 2'd1,
    ST_SAT       = 2'd2,
    ST_TOO_MANY  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_PQ,
    S_MUL_QP,
    S_CROSS,
    S_MUL_MX,
    S_MUL_MY,
    S_ACC_MY,
    S_FINISH,
    S_DIV_PREP,
    S_DIV_STEP,
    S_DIV_STORE,
    S_WRITE
  } state_e;

endpackage

// File: rtl/core/polygon_area_centroid_core.sv
// Polygon area and centroid by the shoelace rule. Vertices arrive one per
// input beat, the final one marked by last_vertex_i; the block then returns
// one result beat with twice the signed area and the centroid in signed 16.8
// fixed point (truncated toward zero, clamped with a flag), or a status code for zero
// area or too many vertices. All arithmetic runs through one shared 17x33
// signed multiplier and one 45-bit compare/subtract divider stage, so the
// block takes one vertex at a time: an ordinary vertex occupies it for
// its accept plus six multiplier/accumulate steps. The final vertex takes
// the same steps for its edge and again for the closing edge, a check step,
// then for nonzero area two restoring divisions (68 quotient steps each,
// plus setup and store), and a load of the output register. A result
// waiting in the output register blocks only the next final vertex, not
// the vertices before it.
module polygon_area_centroid_core #(
  parameter int unsigned MaxVertices = pac_pkg::MAX_VERTICES
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [pac_pkg::COORD_BITS-1:0]   vertex_x_i,
  input  logic signed [pac_pkg::COORD_BITS-1:0]   vertex_y_i,
  input  logic                                    last_vertex_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [pac_pkg::AREA_BITS-1:0]    area_doubled_o,
  output logic signed [pac_pkg::CEN_BITS-1:0]     centroid_x_o,
  output logic signed [pac_pkg::CEN_BITS-1:0]     centroid_y_o,
  output logic        [1:0]                       status_o
);

  localparam int unsigned CntW = $clog2(MaxVertices + 2);
  localparam int unsigned CW   = pac_pkg::COORD_BITS;
  localparam int unsigned SW   = pac_pkg::SUM_BITS;
  localparam int unsigned XW   = pac_pkg::CROSS_BITS;
  localparam int unsigned PW   = pac_pkg::PROD_BITS;
  localparam int unsigned AW   = pac_pkg::AREA_BITS;
  localparam int unsigned MW   = pac_pkg::MOM_BITS;
  localparam int unsigned DW   = pac_pkg::DEN_BITS;
  localparam int unsigned QW   = pac_pkg::QUO_BITS;
  localparam int unsigned NW   = pac_pkg::CEN_BITS;
  localparam int unsigned ItW  = pac_pkg::DIV_IT_BITS;

  localparam logic [QW-1:0] PosLim = QW'((1 << (NW - 1)) - 1);
  localparam logic [QW-1:0] NegLim = QW'(1 << (NW - 1));
  localparam logic [ItW-1:0] ItLast = ItW'(pac_pkg::DIV_STEPS - 1);

  pac_pkg::state_e state_q, state_d;

  // polygon state
  logic [CW-1:0]   first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic [AW-1:0]   area_q;
  logic [MW-1:0]   mom_x_q, mom_y_q;
  logic [CntW-1:0] cnt_q;
  logic            last_q, closing_q;

  // edge datapath
  logic [CW-1:0]        px_q, py_q, qx_q, qy_q;
  logic [SW-1:0]        sx_q, sy_q;
  logic [XW-1:0]        c_q, c_diff;
  logic [PW-1:0]        prod_q;
  logic signed [SW-1:0] mul_a;
  logic signed [XW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;

  // divider
  logic [AW-1:0]  aabs_q;
  logic [DW-1:0]  den_q;
  logic [MW-1:0]  num_q, mom_sel;
  logic [DW-1:0]  rem_q;
  logic [DW:0]    rem_sh, rem_sub;
  logic           rem_ge;
  logic [QW-1:0]  quo_q, lim, mag;
  logic           ovf_q, neg_q, sel_y_q, sat_q, over;
  logic [NW-1:0]  cen_val;
  logic [ItW-1:0] it_q;

  // result staging and output register
  logic [AW-1:0]          res_area_q;
  logic [NW-1:0]          res_cx_q, res_cy_q;
  pac_pkg::status_e       res_status_q;
  logic                   out_valid_q, out_load;
  logic [AW-1:0]          out_area_q;
  logic [NW-1:0]          out_cx_q, out_cy_q;
  pac_pkg::status_e       out_status_q;

  logic in_fire, too_many, zero_area;

  assign in_fire   = in_valid_i && in_ready_o;
  assign too_many  = cnt_q > CntW'(MaxVertices);
  assign zero_area = area_q == '0;
  assign out_load  = (state_q == pac_pkg::S_WRITE) && (!out_valid_q || out_ready_i);

  assign mul_p   = mul_a * mul_b;
  assign c_diff  = c_q - prod_q[XW-1:0];
  assign mom_sel = sel_y_q ? mom_y_q : mom_x_q;
  assign rem_sh  = {rem_q, num_q[MW-1]};
  assign rem_ge  = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign lim     = neg_q ? NegLim : PosLim;
  assign over    = ovf_q || (quo_q > lim);
  assign mag     = over ? lim : quo_q;
  assign cen_val = neg_q ? NW'(-mag) : NW'(mag);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pac_pkg::S_IDLE:     if (in_valid_i) state_d = pac_pkg::S_MUL_PQ;
      pac_pkg::S_MUL_PQ:   state_d = pac_pkg::S_MUL_QP;
      pac_pkg::S_MUL_QP:   state_d = pac_pkg::S_CROSS;
      pac_pkg::S_CROSS:    state_d = pac_pkg::S_MUL_MX;
      pac_pkg::S_MUL_MX:   state_d = pac_pkg::S_MUL_MY;
      pac_pkg::S_MUL_MY:   state_d = pac_pkg::S_ACC_MY;
      pac_pkg::S_ACC_MY: begin
        priority if (last_q && !closing_q) state_d = pac_pkg::S_MUL_PQ;
        else if (last_q)                   state_d = pac_pkg::S_FINISH;
        else                               state_d = pac_pkg::S_IDLE;
      end
      pac_pkg::S_FINISH: begin
        if (too_many || zero_area) state_d = pac_pkg::S_WRITE;
        else                       state_d = pac_pkg::S_DIV_PREP;
      end
      pac_pkg::S_DIV_PREP:  state_d = pac_pkg::S_DIV_STEP;
      pac_pkg::S_DIV_STEP:  if (it_q == ItLast) state_d = pac_pkg::S_DIV_STORE;
      pac_pkg::S_DIV_STORE: state_d = sel_y_q ? pac_pkg::S_WRITE : pac_pkg::S_DIV_PREP;
      pac_pkg::S_WRITE:     if (out_load) state_d = pac_pkg::S_IDLE;
      default:              state_d = pac_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_q)
      pac_pkg::S_IDLE: in_ready_o = 1'b1;
      pac_pkg::S_MUL_PQ: begin
        mul_a = {px_q[CW-1], px_q};
        mul_b = {{(XW - CW){qy_q[CW-1]}}, qy_q};
      end
      pac_pkg::S_MUL_QP: begin
        mul_a = {qx_q[CW-1], qx_q};
        mul_b = {{(XW - CW){py_q[CW-1]}}, py_q};
      end
      pac_pkg::S_MUL_MX: begin
        mul_a = sx_q;
        mul_b = c_q;
      end
      pac_pkg::S_MUL_MY: begin
        mul_a = sy_q;
        mul_b = c_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pac_pkg::S_IDLE;
      first_x_q   <= '0;
      first_y_q   <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      area_q      <= '0;
      mom_x_q     <= '0;
      mom_y_q     <= '0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      closing_q   <= 1'b0;
      sel_y_q     <= 1'b0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        if (cnt_q == '0) begin
          first_x_q <= vertex_x_i;
          first_y_q <= vertex_y_i;
        end
        prev_x_q  <= vertex_x_i;
        prev_y_q  <= vertex_y_i;
        if (!too_many) cnt_q <= cnt_q + 1'b1;
        last_q    <= last_vertex_i;
        closing_q <= 1'b0;
      end
      unique case (state_q)
        pac_pkg::S_CROSS:  area_q  <= area_q + {{(AW - XW){c_diff[XW-1]}}, c_diff};
        pac_pkg::S_MUL_MY: mom_x_q <= mom_x_q + {{(MW - PW){prod_q[PW-1]}}, prod_q};
        pac_pkg::S_ACC_MY: begin
          mom_y_q <= mom_y_q + {{(MW - PW){prod_q[PW-1]}}, prod_q};
          if (last_q) closing_q <= 1'b1;
        end
        pac_pkg::S_FINISH: begin
          sel_y_q <= 1'b0;
          sat_q   <= 1'b0;
        end
        pac_pkg::S_DIV_STORE: begin
          sel_y_q <= 1'b1;
          sat_q   <= sat_q | over;
        end
        pac_pkg::S_WRITE: begin
          if (out_load) begin
            first_x_q <= '0;
            first_y_q <= '0;
            prev_x_q  <= '0;
            prev_y_q  <= '0;
            area_q    <= '0;
            mom_x_q   <= '0;
            mom_y_q   <= '0;
            cnt_q     <= '0;
          end
        end
        default: ;
      endcase
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (in_fire) begin
      px_q <= (cnt_q == '0) ? vertex_x_i : prev_x_q;
      py_q <= (cnt_q == '0) ? vertex_y_i : prev_y_q;
      qx_q <= vertex_x_i;
      qy_q <= vertex_y_i;
    end
    unique case (state_q)
      pac_pkg::S_MUL_PQ: begin
        sx_q <= {px_q[CW-1], px_q} + {qx_q[CW-1], qx_q};
        sy_q <= {py_q[CW-1], py_q} + {qy_q[CW-1], qy_q};
      end
      pac_pkg::S_MUL_QP: c_q <= prod_q[XW-1:0];
      pac_pkg::S_CROSS:  c_q <= c_diff;
      pac_pkg::S_ACC_MY: begin
        // closing edge: current vertex back to the first
        px_q <= qx_q;
        py_q <= qy_q;
        qx_q <= first_x_q;
        qy_q <= first_y_q;
      end
      pac_pkg::S_FINISH: begin
        aabs_q <= area_q[AW-1] ? -area_q : area_q;
        res_cx_q <= '0;
        res_cy_q <= '0;
        if (too_many) begin
          res_area_q   <= '0;
          res_status_q <= pac_pkg::ST_TOO_MANY;
        end else begin
          res_area_q   <= area_q;
          res_status_q <= zero_area ? pac_pkg::ST_ZERO_AREA : pac_pkg::ST_OK;
        end
      end
      pac_pkg::S_DIV_PREP: begin
        den_q <= {1'b0, aabs_q} + {aabs_q, 1'b0};
        num_q <= mom_sel[MW-1] ? -mom_sel : mom_sel;
        neg_q <= mom_sel[MW-1] ^ area_q[AW-1];
        rem_q <= '0;
        quo_q <= '0;
        ovf_q <= 1'b0;
        it_q  <= '0;
      end
      pac_pkg::S_DIV_STEP: begin
        rem_q <= rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        quo_q <= {quo_q[QW-2:0], rem_ge};
        ovf_q <= ovf_q | quo_q[QW-1];
        num_q <= {num_q[MW-2:0], 1'b0};
        it_q  <= it_q + 1'b1;
      end
      pac_pkg::S_DIV_STORE: begin
        if (sel_y_q) begin
          res_cy_q     <= cen_val;
          res_status_q <= (sat_q | over) ? pac_pkg::ST_SAT : pac_pkg::ST_OK;
        end else begin
          res_cx_q <= cen_val;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_area_q   <= res_area_q;
      out_cx_q     <= res_cx_q;
      out_cy_q     <= res_cy_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign area_doubled_o = out_area_q;
  assign centroid_x_o   = out_cx_q;
  assign centroid_y_o   = out_cy_q;
  assign status_o       = out_status_q;

endmodule

// File: rtl/core/pac_checker.sv
module pac_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_ready_o,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic signed [pac_pkg::AREA_BITS-1:0]  area_doubled_o,
  input logic signed [pac_pkg::CEN_BITS-1:0]   centroid_x_o,
  input logic signed [pac_pkg::CEN_BITS-1:0]   centroid_y_o,
  input logic        [1:0]                     status_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(area_doubled_o) &&
    $stable(centroid_x_o) && $stable(centroid_y_o) && $stable(status_o))
    else $error("result beat changed while stalled");

  // each vertex keeps the shared multiplier busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after accept");

  a_flag_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == pac_pkg::ST_TOO_MANY || status_o == pac_pkg::ST_ZERO_AREA)
    |-> area_doubled_o == '0 && centroid_x_o == '0 && centroid_y_o == '0)
    else $error("flagged result carries nonzero fields");

  a_area_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == pac_pkg::ST_OK || status_o == pac_pkg::ST_SAT)
    |-> area_doubled_o != '0)
    else $error("centroid result with zero area");

endmodule

bind polygon_area_centroid_core pac_checker u_pac_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MAX_VTX         = pac_pkg::MAX_VERTICES;
  localparam int          RANDOM_VERTICES = 300;
  localparam int          DRAIN_CYCLES    = 400;
  localparam longint      CYCLE_LIMIT     = 3_000_000;
  localparam int          N_DIRECTED      = 21;

  typedef struct packed {
    logic signed [pac_pkg::AREA_BITS-1:0] area;
    logic signed [pac_pkg::CEN_BITS-1:0]  cx;
    logic signed [pac_pkg::CEN_BITS-1:0]  cy;
    pac_pkg::status_e                     status;
  } centroid_result_t;

  typedef struct {
    logic signed [pac_pkg::COORD_BITS-1:0] x;
    logic signed [pac_pkg::COORD_BITS-1:0] y;
    logic                                  last;
    bit                                    typed;
    centroid_result_t                      want;
  } vertex_row_t;

  typedef enum {POLY_WIDE, POLY_LOCAL, POLY_COLLINEAR} poly_kind_e;

  localparam centroid_result_t NO_RES   = '0;
  localparam centroid_result_t ZERO_RES = '{area: '0, cx: '0, cy: '0,
                                            status: pac_pkg::ST_ZERO_AREA};
  localparam centroid_result_t OVER_RES = '{area: '0, cx: '0, cy: '0,
                                            status: pac_pkg::ST_TOO_MANY};
  localparam longint unsigned  CEN_POS_LIM = (64'd1 << (pac_pkg::CEN_BITS - 1)) - 1;
  localparam longint unsigned  CEN_NEG_LIM = 64'd1 << (pac_pkg::CEN_BITS - 1);

  logic                                   clk_i         = 1'b0;
  logic                                   rst_ni        = 1'b0;
  logic                                   in_valid_i    = 1'b0;
  logic                                   in_ready_o;
  logic signed [pac_pkg::COORD_BITS-1:0]  vertex_x_i    = '0;
  logic signed [pac_pkg::COORD_BITS-1:0]  vertex_y_i    = '0;
  logic                                   last_vertex_i = 1'b0;
  logic                                   out_valid_o;
  logic                                   out_ready_i   = 1'b0;
  logic signed [pac_pkg::AREA_BITS-1:0]   area_doubled_o;
  logic signed [pac_pkg::CEN_BITS-1:0]    centroid_x_o;
  logic signed [pac_pkg::CEN_BITS-1:0]    centroid_y_o;
  logic        [1:0]                      status_o;

  polygon_area_centroid_core u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .vertex_x_i,
    .vertex_y_i,
    .last_vertex_i,
    .out_valid_o,
    .out_ready_i,
    .area_doubled_o,
    .centroid_x_o,
    .centroid_y_o,
    .status_o
  );

  always #5 clk_i = ~clk_i;

  // shoelace accumulator copy
  logic signed [pac_pkg::COORD_BITS-1:0] poly_first_x, poly_first_y, poly_prev_x, poly_prev_y;
  logic        [pac_pkg::AREA_BITS-1:0]  area_acc;
  logic        [pac_pkg::MOM_BITS-1:0]   mom_x_acc, mom_y_acc;
  int unsigned                           vtx_seen;

  centroid_result_t expected_results[$];
  vertex_row_t      directed_rows [N_DIRECTED];

  bit     no_idle_stretch = 1'b0;
  int     error_count     = 0;
  int     vertices_sent   = 0;
  int     polygons_sent   = 0;
  int     results_checked = 0;
  int     status_seen [4] = '{0, 0, 0, 0};
  longint cycle_count     = 0;

  function automatic bit idle_this_cycle();
    return !no_idle_stretch && ($urandom_range(99) < 16);
  endfunction

  function automatic void accumulate_edge(input longint px, input longint py,
                                          input longint qx, input longint qy);
    longint cross_prod;
    cross_prod = px * qy - qx * py;
    area_acc   = area_acc + pac_pkg::AREA_BITS'(cross_prod);
    mom_x_acc  = mom_x_acc + pac_pkg::MOM_BITS'((px + qx) * cross_prod);
    mom_y_acc  = mom_y_acc + pac_pkg::MOM_BITS'((py + qy) * cross_prod);
  endfunction

  // moment * 256 / (3 * area2), truncated toward zero, clamped
  function automatic logic signed [pac_pkg::CEN_BITS-1:0] centroid_coord(
      input longint num, input longint a2, inout bit sat);
    bit              neg;
    longint unsigned n, d, q, r, lim, mag;
    neg = (num < 0) != (a2 < 0);
    n   = (num < 0) ? -num : num;
    d   = 3 * ((a2 < 0) ? -a2 : a2);
    q   = n / d;
    r   = n % d;
    lim = neg ? CEN_NEG_LIM : CEN_POS_LIM;
    if (q >= 64'd65536) begin
      mag = lim + 1;
    end else begin
      mag = (q << pac_pkg::FRAC_BITS) + (r << pac_pkg::FRAC_BITS) / d;
    end
    if (mag > lim) begin
      mag = lim;
      sat = 1'b1;
    end
    return neg ? pac_pkg::CEN_BITS'(-mag) : pac_pkg::CEN_BITS'(mag);
  endfunction

  function automatic bit shoelace_step(input logic signed [pac_pkg::COORD_BITS-1:0] x,
                                       input logic signed [pac_pkg::COORD_BITS-1:0] y,
                                       input logic last,
                                       output centroid_result_t res);
    longint a2;
    bit     sat;
    res = NO_RES;
    sat = 1'b0;
    if (vtx_seen == 0) begin
      poly_first_x = x;
      poly_first_y = y;
    end else begin
      accumulate_edge(poly_prev_x, poly_prev_y, x, y);
    end
    poly_prev_x = x;
    poly_prev_y = y;
    if (vtx_seen <= MAX_VTX) vtx_seen++;
    if (!last) return 1'b0;

    accumulate_edge(x, y, poly_first_x, poly_first_y);
    a2 = $signed(area_acc);
    if (vtx_seen > MAX_VTX) begin
      res.status = pac_pkg::ST_TOO_MANY;
    end else if (a2 == 0) begin
      res.status = pac_pkg::ST_ZERO_AREA;
    end else begin
      res.area   = pac_pkg::AREA_BITS'(a2);
      res.cx     = centroid_coord($signed(mom_x_acc), a2, sat);
      res.cy     = centroid_coord($signed(mom_y_acc), a2, sat);
      res.status = sat ? pac_pkg::ST_SAT : pac_pkg::ST_OK;
    end
    poly_first_x = '0;
    poly_first_y = '0;
    poly_prev_x  = '0;
    poly_prev_y  = '0;
    area_acc     = '0;
    mom_x_acc    = '0;
    mom_y_acc    = '0;
    vtx_seen     = 0;
    return 1'b1;
  endfunction

  task automatic drive_vertex(input logic signed [pac_pkg::COORD_BITS-1:0] x,
                              input logic signed [pac_pkg::COORD_BITS-1:0] y,
                              input logic last, input bit typed,
                              input centroid_result_t want);
    centroid_result_t got;
    @(negedge clk_i);
    while (idle_this_cycle()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    vertex_x_i    <= x;
    vertex_y_i    <= y;
    last_vertex_i <= last;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    if (shoelace_step(x, y, last, got)) begin
      expected_results.push_back(typed ? want : got);
      polygons_sent++;
    end
    vertices_sent++;
  endtask

  task automatic send_polygon(input int n, input poly_kind_e kind, input bit over_limit);
    int                                    span, x0, y0, dx, dy;
    logic signed [pac_pkg::COORD_BITS-1:0] vx, vy;
    span = ($urandom_range(3) == 0) ? int'($urandom_range(1, 16))
                                    : int'($urandom_range(1, 4096));
    x0   = int'($urandom_range(65535 - 2 * span)) - 32768 + span;
    y0   = int'($urandom_range(65535 - 2 * span)) - 32768 + span;
    dx   = int'($urandom_range(1000)) - 500;
    dy   = int'($urandom_range(1000)) - 500;
    if (kind == POLY_COLLINEAR) begin
      x0 = int'($urandom_range(40000)) - 20000;
      y0 = int'($urandom_range(40000)) - 20000;
    end
    for (int k = 0; k < n; k++) begin
      case (kind)
        POLY_WIDE: begin
          vx = pac_pkg::COORD_BITS'($urandom());
          vy = pac_pkg::COORD_BITS'($urandom());
        end
        POLY_LOCAL: begin
          vx = pac_pkg::COORD_BITS'(x0 + int'($urandom_range(2 * span)) - span);
          vy = pac_pkg::COORD_BITS'(y0 + int'($urandom_range(2 * span)) - span);
        end
        default: begin
          vx = pac_pkg::COORD_BITS'(x0 + k * dx);
          vy = pac_pkg::COORD_BITS'(y0 + k * dy);
        end
      endcase
      drive_vertex(vx, vy, k == n - 1, over_limit, OVER_RES);
    end
  endtask

  // result side: random back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= !idle_this_cycle();
  end

  always @(posedge clk_i) begin
    centroid_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: area_doubled %0d status %0d",
               area_doubled_o, status_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (area_doubled_o !== want.area) begin
          $error("area_doubled: expected %0d, got %0d", want.area, area_doubled_o);
          error_count++;
        end
        if (centroid_x_o !== want.cx) begin
          $error("centroid_x: expected %0d, got %0d", want.cx, centroid_x_o);
          error_count++;
        end
        if (centroid_y_o !== want.cy) begin
          $error("centroid_y: expected %0d, got %0d", want.cy, centroid_y_o);
          error_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_count++;
        end
        results_checked++;
        status_seen[want.status]++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("** polygon_area_centroid_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int rand_start;
    int pick;
    directed_rows = '{
      '{16'sd0,       16'sd0,       1'b1, 1'b1, ZERO_RES},
      '{16'sh8000,    16'sd32767,   1'b1, 1'b1, ZERO_RES},
      '{16'sd32767,   16'sh8000,    1'b0, 1'b0, NO_RES},
      '{16'sh8000,    16'sd32767,   1'b1, 1'b1, ZERO_RES},
      '{-16'sd100,    -16'sd100,    1'b0, 1'b0, NO_RES},
      '{16'sd0,       16'sd0,       1'b0, 1'b0, NO_RES},
      '{16'sd300,     16'sd300,     1'b1, 1'b1, ZERO_RES},
      '{16'sd0,       16'sd0,       1'b0, 1'b0, NO_RES},
      '{16'sd256,     16'sd0,       1'b0, 1'b0, NO_RES},
      '{16'sd0,       16'sd256,     1'b1, 1'b0, NO_RES},
      '{16'sd0,       16'sd0,       1'b0, 1'b0, NO_RES},
      '{16'sd0,       16'sd256,     1'b0, 1'b0, NO_RES},
      '{16'sd256,     16'sd0,       1'b1, 1'b0, NO_RES},
      '{16'sh8000,    16'sh8000,    1'b0, 1'b0, NO_RES},
      '{16'sd32767,   16'sh8000,    1'b0, 1'b0, NO_RES},
      '{16'sd32767,   16'sd32767,   1'b0, 1'b0, NO_RES},
      '{16'sh8000,    16'sd32767,   1'b1, 1'b0, NO_RES},
      '{16'sd0,       16'sd0,       1'b0, 1'b0, NO_RES},
      '{16'sd20000,   16'sd20000,   1'b0, 1'b0, NO_RES},
      '{16'sd20000,   16'sd0,       1'b0, 1'b0, NO_RES},
      '{16'sd0,       16'sd20001,   1'b1, 1'b0, NO_RES}
    };
    poly_first_x = '0;
    poly_first_y = '0;
    poly_prev_x  = '0;
    poly_prev_y  = '0;
    area_acc     = '0;
    mom_x_acc    = '0;
    mom_y_acc    = '0;
    vtx_seen     = 0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      drive_vertex(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].want);
    end

    // vertex limit: one over
    send_polygon(MAX_VTX + 1, POLY_LOCAL, 1'b1);

    rand_start = vertices_sent;
    while (vertices_sent - rand_start < RANDOM_VERTICES) begin
      no_idle_stretch = (vertices_sent - rand_start >= 100) &&
                        (vertices_sent - rand_start < 220);
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_polygon($urandom_range(3, 12), POLY_LOCAL, 1'b0);
      end else if (pick < 65) begin
        send_polygon($urandom_range(1, 12), POLY_WIDE, 1'b0);
      end else if (pick < 80) begin
        send_polygon($urandom_range(1, 6), POLY_COLLINEAR, 1'b0);
      end else begin
        send_polygon($urandom_range(13, 60), POLY_LOCAL, 1'b0);
      end
    end
    no_idle_stretch = 1'b0;

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d vertices in %0d polygons, %0d results checked", vertices_sent,
             polygons_sent, results_checked);
    $display("status mix: ok %0d, zero area %0d, clamped %0d, over limit %0d",
             status_seen[pac_pkg::ST_OK], status_seen[pac_pkg::ST_ZERO_AREA],
             status_seen[pac_pkg::ST_SAT], status_seen[pac_pkg::ST_TOO_MANY]);
    if (error_count == 0) begin
      $display("** polygon_area_centroid_core: PASSED **");
    end else begin
      $display("** polygon_area_centroid_core: FAILED **");
    end
    $finish;
  end

endmodule
